[src/ohlc_pkg.sv]
// Shared types, constants and helper functions for the OHLC bar aggregator.
package ohlc_pkg;

  localparam int unsigned HourW     = 5;
  localparam int unsigned MinuteW   = 6;
  localparam int unsigned PriceW    = 32;
  localparam int unsigned TickVolW  = 32;
  localparam int unsigned TickTurnW = 40;
  localparam int unsigned BarVolW   = 48;
  localparam int unsigned BarTurnW  = 63;
  localparam int unsigned ClockW    = 12;  // hour*100 + minute, up to 31*100 + 63

  localparam logic [MinuteW-1:0] BarMinutesReset = MinuteW'(1);
  localparam logic [MinuteW-1:0] AlignStep       = MinuteW'(15);

  // Session boundaries as hour*100 + minute.
  localparam logic [ClockW-1:0] MorningOpen  = ClockW'(900);
  localparam logic [ClockW-1:0] BreakStart   = ClockW'(1015);
  localparam logic [ClockW-1:0] BreakEnd     = ClockW'(1030);
  localparam logic [ClockW-1:0] LunchStart   = ClockW'(1130);
  localparam logic [ClockW-1:0] LunchEnd     = ClockW'(1330);
  localparam logic [ClockW-1:0] DayClose     = ClockW'(1500);
  localparam logic [ClockW-1:0] NightOpen    = ClockW'(2100);
  localparam logic [ClockW-1:0] NightClose   = ClockW'(2300);

  localparam logic [BarVolW-1:0]  VolMax  = {BarVolW{1'b1}};
  localparam logic [BarTurnW-1:0] TurnMax = {BarTurnW{1'b1}};

  // Tick held in the input register.
  typedef struct packed {
    logic [HourW-1:0]     hour;
    logic [MinuteW-1:0]   minute;
    logic [MinuteW-1:0]   minute_aligned;
    logic [PriceW-1:0]    price;
    logic [TickVolW-1:0]  volume;
    logic [TickTurnW-1:0] turnover;
  } tick_t;

  // Status from the bar stage back to the input stage and the checks.
  typedef struct packed {
    logic advance;
    logic emit;
  } bar_status_t;

  function automatic logic [ClockW-1:0] clock_value(input logic [HourW-1:0] hour,
                                                    input logic [MinuteW-1:0] minute);
    return ClockW'(hour) * ClockW'(100) + ClockW'(minute);
  endfunction

  function automatic logic session_closed(input logic [ClockW-1:0] t);
    return (t < MorningOpen) ||
           ((t >= BreakStart) && (t < BreakEnd)) ||
           ((t >= LunchStart) && (t < LunchEnd)) ||
           ((t >= DayClose) && (t < NightOpen)) ||
           (t >= NightClose);
  endfunction

  // Round down to a multiple of 15 (minute is at most 63).
  function automatic logic [MinuteW-1:0] align_minute(input logic [MinuteW-1:0] minute);
    logic [MinuteW-1:0] r;
    r = '0;
    if (minute >= MinuteW'(4 * AlignStep)) r = MinuteW'(4 * AlignStep);
    else if (minute >= MinuteW'(3 * AlignStep)) r = MinuteW'(3 * AlignStep);
    else if (minute >= MinuteW'(2 * AlignStep)) r = MinuteW'(2 * AlignStep);
    else if (minute >= AlignStep) r = AlignStep;
    return r;
  endfunction

endpackage

[src/ohlc_if.sv]
// Valid/ready channel interfaces for ticks in and closed bars out.
interface ohlc_tick_if;
  logic                               valid;
  logic                               ready;
  logic [ohlc_pkg::HourW-1:0]         tick_hour;
  logic [ohlc_pkg::MinuteW-1:0]       tick_minute;
  logic [ohlc_pkg::PriceW-1:0]        last_price;
  logic [ohlc_pkg::TickVolW-1:0]      tick_volume;
  logic [ohlc_pkg::TickTurnW-1:0]     tick_turnover;

  modport source(output valid, tick_hour, tick_minute, last_price, tick_volume,
                 tick_turnover, input ready);
  modport sink(input valid, tick_hour, tick_minute, last_price, tick_volume,
               tick_turnover, output ready);
endinterface

interface ohlc_bar_if;
  logic                           valid;
  logic                           ready;
  logic [ohlc_pkg::PriceW-1:0]    bar_open;
  logic [ohlc_pkg::PriceW-1:0]    bar_high;
  logic [ohlc_pkg::PriceW-1:0]    bar_low;
  logic [ohlc_pkg::PriceW-1:0]    bar_close;
  logic [ohlc_pkg::BarVolW-1:0]   bar_volume;
  logic [ohlc_pkg::BarTurnW-1:0]  bar_turnover;
  logic [ohlc_pkg::HourW-1:0]     bar_start_hour;
  logic [ohlc_pkg::MinuteW-1:0]   bar_start_minute;

  modport source(output valid, bar_open, bar_high, bar_low, bar_close, bar_volume,
                 bar_turnover, bar_start_hour, bar_start_minute, input ready);
  modport sink(input valid, bar_open, bar_high, bar_low, bar_close, bar_volume,
               bar_turnover, bar_start_hour, bar_start_minute, output ready);
endinterface

[src/ohlc_ingress.sv]
// Input register with the trading session filter.
module ohlc_ingress (
  input  logic                  clk,
  input  logic                  rst,
  ohlc_tick_if.sink             tick,
  input  ohlc_pkg::bar_status_t status,
  output logic                  held_valid,
  output ohlc_pkg::tick_t       held
);

  logic closed;
  logic take;

  assign closed     = ohlc_pkg::session_closed(
                        ohlc_pkg::clock_value(tick.tick_hour, tick.tick_minute));
  assign tick.ready = !held_valid || status.advance;
  assign take       = tick.valid && tick.ready;

  // Drop closed-session ticks at the door: they never reach the bar stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (take) begin
      held_valid <= !closed;
    end else if (status.advance) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      held.hour           <= tick.tick_hour;
      held.minute         <= tick.tick_minute;
      held.minute_aligned <= ohlc_pkg::align_minute(tick.tick_minute);
      held.price          <= tick.last_price;
      held.volume         <= tick.tick_volume;
      held.turnover       <= tick.tick_turnover;
    end
  end

endmodule

[src/ohlc_bar_state.sv]
// Open bar state, bar close decision and the result register.
module ohlc_bar_state (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [ohlc_pkg::MinuteW-1:0]  bar_minutes,
  input  logic                          held_valid,
  input  ohlc_pkg::tick_t               held,
  output ohlc_pkg::bar_status_t         status,
  ohlc_bar_if.source                    bar
);

  logic                           bar_exists;
  logic [ohlc_pkg::PriceW-1:0]    open_price;
  logic [ohlc_pkg::PriceW-1:0]    high_price;
  logic [ohlc_pkg::PriceW-1:0]    low_price;
  logic [ohlc_pkg::PriceW-1:0]    close_price;
  logic [ohlc_pkg::BarVolW-1:0]   volume_sum;
  logic [ohlc_pkg::BarTurnW-1:0]  turnover_sum;
  logic [ohlc_pkg::HourW-1:0]     start_hour;
  logic [ohlc_pkg::MinuteW-1:0]   start_minute;

  logic [ohlc_pkg::MinuteW:0]     close_edge;
  logic                           emit;
  logic                           advance;
  logic [ohlc_pkg::BarVolW:0]     vol_sum;
  logic [ohlc_pkg::BarTurnW:0]    turn_sum;
  logic [ohlc_pkg::BarVolW-1:0]   volume_sum_next;
  logic [ohlc_pkg::BarTurnW-1:0]  turnover_sum_next;

  // minute - start >= length, written without a signed subtract
  assign close_edge = {1'b0, start_minute} + {1'b0, bar_minutes};
  assign emit       = bar_exists &&
                      ((held.hour != start_hour) ||
                       ({1'b0, held.minute} >= close_edge));
  // Hold the tick while a closed bar has nowhere to go.
  assign advance    = held_valid && (!emit || !bar.valid || bar.ready);

  assign status.advance = advance;
  assign status.emit    = emit;

  assign vol_sum  = {1'b0, volume_sum} + (ohlc_pkg::BarVolW + 1)'(held.volume);
  assign turn_sum = {1'b0, turnover_sum} + (ohlc_pkg::BarTurnW + 1)'(held.turnover);
  assign volume_sum_next   = vol_sum[ohlc_pkg::BarVolW] ? ohlc_pkg::VolMax
                                                        : vol_sum[ohlc_pkg::BarVolW-1:0];
  assign turnover_sum_next = turn_sum[ohlc_pkg::BarTurnW] ? ohlc_pkg::TurnMax
                                                          : turn_sum[ohlc_pkg::BarTurnW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      bar_exists   <= 1'b0;
      open_price   <= '0;
      high_price   <= '0;
      low_price    <= '0;
      close_price  <= '0;
      volume_sum   <= '0;
      turnover_sum <= '0;
      start_hour   <= '0;
      start_minute <= '0;
    end else if (advance) begin
      if (!bar_exists || emit) begin
        bar_exists   <= 1'b1;
        open_price   <= held.price;
        high_price   <= held.price;
        low_price    <= held.price;
        close_price  <= held.price;
        volume_sum   <= ohlc_pkg::BarVolW'(held.volume);
        turnover_sum <= ohlc_pkg::BarTurnW'(held.turnover);
        start_hour   <= held.hour;
        // first bar keeps its raw minute
        start_minute <= bar_exists ? held.minute_aligned : held.minute;
      end else begin
        close_price  <= held.price;
        if (held.price > high_price) high_price <= held.price;
        if (held.price < low_price) low_price <= held.price;
        volume_sum   <= volume_sum_next;
        turnover_sum <= turnover_sum_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bar.valid <= 1'b0;
    end else if (advance && emit) begin
      bar.valid <= 1'b1;
    end else if (bar.ready) begin
      bar.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      bar.bar_open         <= open_price;
      bar.bar_high         <= high_price;
      bar.bar_low          <= low_price;
      bar.bar_close        <= close_price;
      bar.bar_volume       <= volume_sum;
      bar.bar_turnover     <= turnover_sum;
      bar.bar_start_hour   <= start_hour;
      bar.bar_start_minute <= start_minute;
    end
  end

endmodule

[src/tick_to_ohlc_bar_aggregator.sv]
// Flow: a taken tick waits in the input register; the bar it closes is written to the
// result register as the tick advances out of the input register.
// Throughput: one tick per cycle; a tick stalls only when it closes a bar while the
// previous result is still untaken.
// Reset (rst, synchronous): no open bar, bar_minutes = 1, no result pending.
module tick_to_ohlc_bar_aggregator (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [ohlc_pkg::MinuteW-1:0]  cfg_data,
  ohlc_tick_if.sink                     tick,
  ohlc_bar_if.source                    bar
);

  logic [ohlc_pkg::MinuteW-1:0] bar_minutes;
  logic                   held_valid;
  ohlc_pkg::tick_t        held;
  ohlc_pkg::bar_status_t  status;

  always_ff @(posedge clk) begin
    if (rst) begin
      bar_minutes <= ohlc_pkg::BarMinutesReset;
    end else if (cfg_write) begin
      bar_minutes <= cfg_data;
    end
  end

  ohlc_ingress u_ingress (
    .clk        (clk),
    .rst        (rst),
    .tick       (tick),
    .status     (status),
    .held_valid (held_valid),
    .held       (held)
  );

  ohlc_bar_state u_bar_state (
    .clk         (clk),
    .rst         (rst),
    .bar_minutes (bar_minutes),
    .held_valid  (held_valid),
    .held        (held),
    .status      (status),
    .bar         (bar)
  );

  // A held tick that cannot advance must still be held next cycle.
  a_hold_stalled: assert property (@(posedge clk) disable iff (rst)
    (held_valid && !status.advance) |=> held_valid)
    else $error("stalled tick lost");

  // A closing tick never advances over an untaken result.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (status.advance && status.emit) |-> (!bar.valid || bar.ready))
    else $error("result overwritten");

  // Low never exceeds high in a delivered bar.
  a_low_high: assert property (@(posedge clk) disable iff (rst)
    bar.valid |-> (bar.bar_low <= bar.bar_high))
    else $error("bar low above high");

  // A waiting result holds its valid and payload until the transfer.
  a_bar_hold: assert property (@(posedge clk) disable iff (rst)
    (bar.valid && !bar.ready) |=>
      (bar.valid && $stable(bar.bar_open) && $stable(bar.bar_volume) &&
       $stable(bar.bar_turnover) && $stable(bar.bar_start_minute)))
    else $error("waiting bar changed");

endmodule

[tb/sv/tb_top.sv]
// Testbench for the tick to OHLC bar aggregator: random ticks in, closed bars checked.
`timescale 1ns / 100ps

module tb_top;

  localparam int SettleCycles = 4;
  localparam int PhaseTicks   = 189;

  typedef struct packed {
    logic [ohlc_pkg::HourW-1:0]     hour;
    logic [ohlc_pkg::MinuteW-1:0]   minute;
    logic [ohlc_pkg::PriceW-1:0]    price;
    logic [ohlc_pkg::TickVolW-1:0]  volume;
    logic [ohlc_pkg::TickTurnW-1:0] turnover;
  } tick_item_t;

  typedef struct packed {
    logic [ohlc_pkg::PriceW-1:0]   open_px;
    logic [ohlc_pkg::PriceW-1:0]   high_px;
    logic [ohlc_pkg::PriceW-1:0]   low_px;
    logic [ohlc_pkg::PriceW-1:0]   close_px;
    logic [ohlc_pkg::BarVolW-1:0]  volume;
    logic [ohlc_pkg::BarTurnW-1:0] turnover;
    logic [ohlc_pkg::HourW-1:0]    hour;
    logic [ohlc_pkg::MinuteW-1:0]  minute;
  } bar_item_t;

  typedef enum {RdyAlways, RdyCoin, RdySparse, RdyRuns} ready_mode_t;

  logic                         clk = 1'b0;
  logic                         rst;
  logic                         cfg_write;
  logic [ohlc_pkg::MinuteW-1:0] cfg_data;

  ohlc_tick_if tick_ch();
  ohlc_bar_if  bar_ch();

  tick_to_ohlc_bar_aggregator uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .tick      (tick_ch),
    .bar       (bar_ch)
  );

  always #6 clk = ~clk;

  // Bar state as the block should hold it.
  logic [ohlc_pkg::MinuteW-1:0]  bar_len    = ohlc_pkg::BarMinutesReset;
  bit                            have_bar   = 1'b0;
  logic [ohlc_pkg::PriceW-1:0]   open_px    = '0;
  logic [ohlc_pkg::PriceW-1:0]   high_px    = '0;
  logic [ohlc_pkg::PriceW-1:0]   low_px     = '0;
  logic [ohlc_pkg::PriceW-1:0]   close_px   = '0;
  logic [ohlc_pkg::BarVolW-1:0]  vol_acc    = '0;
  logic [ohlc_pkg::BarTurnW-1:0] turn_acc   = '0;
  logic [ohlc_pkg::HourW-1:0]    bar_hour   = '0;
  logic [ohlc_pkg::MinuteW-1:0]  bar_minute = '0;

  tick_item_t pending_ticks[$];
  bar_item_t  bar_expected[$];

  int mismatches    = 0;
  int ticks_taken   = 0;
  int ticks_dropped = 0;
  int bars_checked  = 0;
  int settings_used = 1;

  function automatic bit outside_session(input logic [ohlc_pkg::HourW-1:0] h,
                                         input logic [ohlc_pkg::MinuteW-1:0] m);
    int c;
    c = int'(h) * 100 + int'(m);
    return c < int'(ohlc_pkg::MorningOpen) ||
           (c >= int'(ohlc_pkg::BreakStart) && c < int'(ohlc_pkg::BreakEnd)) ||
           (c >= int'(ohlc_pkg::LunchStart) && c < int'(ohlc_pkg::LunchEnd)) ||
           (c >= int'(ohlc_pkg::DayClose) && c < int'(ohlc_pkg::NightOpen)) ||
           c >= int'(ohlc_pkg::NightClose);
  endfunction

  function void open_bar(input tick_item_t t,
                         input logic [ohlc_pkg::MinuteW-1:0] start_min);
    have_bar   = 1'b1;
    open_px    = t.price;
    high_px    = t.price;
    low_px     = t.price;
    close_px   = t.price;
    vol_acc    = ohlc_pkg::BarVolW'(t.volume);
    turn_acc   = ohlc_pkg::BarTurnW'(t.turnover);
    bar_hour   = t.hour;
    bar_minute = start_min;
  endfunction

  function void predict_tick(input tick_item_t t);
    int          diff;
    logic [63:0] sum;
    bar_item_t   b;
    if (outside_session(t.hour, t.minute)) begin
      ticks_dropped++;
      return;
    end
    diff = int'(t.minute) - int'(bar_minute);
    if (!have_bar) begin
      // first bar keeps its minute unrounded
      open_bar(t, t.minute);
    end else if (t.hour != bar_hour || diff >= int'(bar_len)) begin
      b.open_px  = open_px;
      b.high_px  = high_px;
      b.low_px   = low_px;
      b.close_px = close_px;
      b.volume   = vol_acc;
      b.turnover = turn_acc;
      b.hour     = bar_hour;
      b.minute   = bar_minute;
      bar_expected.push_back(b);
      open_bar(t, t.minute - (t.minute % ohlc_pkg::AlignStep));
    end else begin
      close_px = t.price;
      if (t.price > high_px) high_px = t.price;
      if (t.price < low_px) low_px = t.price;
      sum = 64'(vol_acc) + 64'(t.volume);
      vol_acc = (sum > 64'(ohlc_pkg::VolMax)) ? ohlc_pkg::VolMax
                                              : sum[ohlc_pkg::BarVolW-1:0];
      sum = 64'(turn_acc) + 64'(t.turnover);
      turn_acc = (sum > 64'(ohlc_pkg::TurnMax)) ? ohlc_pkg::TurnMax
                                                : sum[ohlc_pkg::BarTurnW-1:0];
    end
  endfunction

  function void check_field(input string name, input logic [63:0] want,
                            input logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endfunction

  // Sender: bursts of transfers separated by random gaps.
  tick_item_t  cur_tick;
  int unsigned burst_left = 0;
  int unsigned gap_left   = 0;

  always @(posedge clk) begin : tick_driver
    if (rst) begin
      tick_ch.valid <= 1'b0;
      burst_left = 0;
      gap_left   = 0;
    end else begin
      if (tick_ch.valid && tick_ch.ready) begin
        predict_tick(cur_tick);
        ticks_taken++;
      end
      // hold the item while it waits for ready
      if (!tick_ch.valid || tick_ch.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          tick_ch.valid <= 1'b0;
        end else if (pending_ticks.size() > 0) begin
          cur_tick = pending_ticks.pop_front();
          tick_ch.valid         <= 1'b1;
          tick_ch.tick_hour     <= cur_tick.hour;
          tick_ch.tick_minute   <= cur_tick.minute;
          tick_ch.last_price    <= cur_tick.price;
          tick_ch.tick_volume   <= cur_tick.volume;
          tick_ch.tick_turnover <= cur_tick.turnover;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(64, 200)
                                                      : $urandom_range(1, 16);
            gap_left = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 8);
          end
        end else begin
          tick_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: ready follows a pattern that changes mode every so often.
  ready_mode_t rdy_mode  = RdyAlways;
  int unsigned mode_left = 0;
  int unsigned run_left  = 0;
  bit          run_high  = 1'b0;

  always @(posedge clk) begin : bar_monitor
    bar_item_t want;
    logic      ready_now;
    if (rst) begin
      bar_ch.ready <= 1'b0;
    end else begin
      if (bar_ch.valid && bar_ch.ready) begin
        if (bar_expected.size() == 0) begin
          $error("bar transfer with no closed bar expected");
          mismatches++;
        end else begin
          want = bar_expected.pop_front();
          check_field("bar_open", want.open_px, bar_ch.bar_open);
          check_field("bar_high", want.high_px, bar_ch.bar_high);
          check_field("bar_low", want.low_px, bar_ch.bar_low);
          check_field("bar_close", want.close_px, bar_ch.bar_close);
          check_field("bar_volume", want.volume, bar_ch.bar_volume);
          check_field("bar_turnover", want.turnover, bar_ch.bar_turnover);
          check_field("bar_start_hour", want.hour, bar_ch.bar_start_hour);
          check_field("bar_start_minute", want.minute, bar_ch.bar_start_minute);
          bars_checked++;
        end
      end
      if (mode_left == 0) begin
        rdy_mode  = ready_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(32, 256);
      end else begin
        mode_left--;
      end
      case (rdy_mode)
        RdyAlways: ready_now = 1'b1;
        RdyCoin:   ready_now = 1'($urandom_range(0, 1));
        RdySparse: ready_now = ($urandom_range(0, 3) == 0);
        default: begin
          if (run_left == 0) begin
            run_high = !run_high;
            run_left = $urandom_range(1, 12);
          end else begin
            run_left--;
          end
          ready_now = run_high;
        end
      endcase
      bar_ch.ready <= ready_now;
    end
  end

  // Tick generator state: a session clock that mostly moves forward.
  int          OpenHours[7] = '{9, 10, 11, 13, 14, 21, 22};
  int          gen_hour_idx = 0;
  int          gen_minute   = 0;
  logic [31:0] gen_price    = 32'd500000;

  task automatic push_tick(input logic [ohlc_pkg::HourW-1:0] h,
                           input logic [ohlc_pkg::MinuteW-1:0] m,
                           input logic [31:0] p, input logic [31:0] v,
                           input logic [39:0] tr);
    tick_item_t t;
    t.hour     = h;
    t.minute   = m;
    t.price    = p;
    t.volume   = v;
    t.turnover = tr;
    pending_ticks.push_back(t);
  endtask

  task automatic gen_random_tick();
    tick_item_t  t;
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 10) begin
      // noise anywhere on the clock
      t.hour   = ohlc_pkg::HourW'($urandom_range(0, 31));
      t.minute = ohlc_pkg::MinuteW'($urandom_range(0, 63));
    end else begin
      if (roll < 15) gen_minute = (gen_minute > 20) ? gen_minute - int'($urandom_range(1, 20)) : 0;
      else if (roll < 22) gen_minute += int'($urandom_range(3, 20));
      else gen_minute += int'($urandom_range(0, 2));
      if (gen_minute > 63 || (gen_minute > 59 && $urandom_range(0, 3) != 0)) begin
        gen_hour_idx = ($urandom_range(0, 19) == 0) ? int'($urandom_range(0, 6))
                                                    : (gen_hour_idx + 1) % 7;
        gen_minute = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 40)) : 0;
      end
      t.hour   = ohlc_pkg::HourW'(OpenHours[gen_hour_idx]);
      t.minute = ohlc_pkg::MinuteW'(gen_minute);
    end
    roll = $urandom_range(0, 99);
    if (roll < 8) gen_price = $urandom;
    else if (roll < 10) gen_price = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
    else gen_price = gen_price + $urandom_range(0, 4000) - 32'd2000;
    t.price = gen_price;
    roll = $urandom_range(0, 99);
    if (roll < 80) t.volume = $urandom_range(0, 5000);
    else if (roll < 95) t.volume = $urandom;
    else t.volume = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
    roll = $urandom_range(0, 99);
    if (roll < 80) t.turnover = ohlc_pkg::TickTurnW'($urandom_range(0, 1000000));
    else if (roll < 95) t.turnover = {8'($urandom_range(0, 255)), 32'($urandom)};
    else t.turnover = $urandom_range(0, 1) ? {ohlc_pkg::TickTurnW{1'b1}} : '0;
    pending_ticks.push_back(t);
  endtask

  // Drain both channels, then give the bar stage time to absorb the last tick.
  task automatic wait_idle();
    do @(negedge clk);
    while (pending_ticks.size() != 0 || tick_ch.valid || bar_expected.size() != 0);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_bar_len(input logic [ohlc_pkg::MinuteW-1:0] v);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_data  <= v;
    bar_len = v;
    settings_used++;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  initial begin : stimulus
    logic [ohlc_pkg::MinuteW-1:0] settings[7];
    rst       <= 1'b1;
    cfg_write <= 1'b0;
    cfg_data  <= ohlc_pkg::BarMinutesReset;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed: session edges, extremes, first bar, earlier minute, minutes 60..63.
    push_tick(8, 59, 32'd1, 32'd1, 40'd1);
    push_tick(9, 7, 32'd100, 32'hFFFF_FFFF, {ohlc_pkg::TickTurnW{1'b1}});
    push_tick(9, 7, 32'hFFFF_FFFF, 32'd0, 40'd0);
    push_tick(9, 7, 32'd0, 32'd1, 40'd1);
    push_tick(9, 3, 32'd50, 32'd2, 40'd2);
    push_tick(9, 8, 32'd200, 32'd3, 40'd3);
    push_tick(10, 14, 32'd300, 32'd4, 40'd4);
    push_tick(10, 15, 32'd310, 32'd5, 40'd5);
    push_tick(10, 29, 32'd320, 32'd6, 40'd6);
    push_tick(10, 30, 32'd330, 32'd7, 40'd7);
    push_tick(11, 29, 32'd340, 32'd8, 40'd8);
    push_tick(11, 30, 32'd350, 32'd9, 40'd9);
    push_tick(13, 29, 32'd360, 32'd10, 40'd10);
    push_tick(13, 30, 32'd370, 32'd11, 40'd11);
    push_tick(14, 59, 32'd380, 32'd12, 40'd12);
    push_tick(15, 0, 32'd390, 32'd13, 40'd13);
    push_tick(20, 59, 32'd400, 32'd14, 40'd14);
    push_tick(21, 0, 32'd410, 32'd15, 40'd15);
    push_tick(22, 59, 32'd420, 32'd16, 40'd16);
    push_tick(23, 0, 32'd430, 32'd17, 40'd17);
    push_tick(24, 0, 32'd440, 32'd18, 40'd18);
    push_tick(31, 63, 32'hFFFF_FFFF, 32'hFFFF_FFFF, {ohlc_pkg::TickTurnW{1'b1}});
    push_tick(9, 60, 32'd450, 32'd19, 40'd19);
    push_tick(9, 63, 32'd460, 32'd20, 40'd20);
    push_tick(0, 0, 32'd0, 32'd0, 40'd0);
    wait_idle();

    settings = '{6'd0, 6'd63, 6'd60, 6'd15, 6'd5, 6'd1, 6'd0};
    settings[6] = ohlc_pkg::MinuteW'($urandom_range(2, 59));
    foreach (settings[p]) begin
      write_bar_len(settings[p]);
      for (int i = 0; i < PhaseTicks; i++) gen_random_tick();
      wait_idle();
    end

    $display("Checked %0d closed bars from %0d tick transfers, %0d outside trading sessions.",
             bars_checked, ticks_taken, ticks_dropped);
    $display("Bar length took %0d settings including 0, 63 and one random length.",
             settings_used);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
